FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the merge RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, disabled while reset is low.
`define AAM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Clocked on i_clk, disabled by i_rst_n of the enclosing module.
`define AAM_ASSERT(label, prop, msg) \
    `AAM_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

FILE: hw/rtl/aam_pkg.sv
// ----------------------------------------------------------------------------
// aam_pkg
// Types and constants for the anchored alignment merge.
// ----------------------------------------------------------------------------
package aam_pkg;

    localparam int MAX_COLUMNS_DEF = 32;

    // operation codes
    localparam logic [1:0] OP_LOAD_ONE = 2'd0;
    localparam logic [1:0] OP_LOAD_TWO = 2'd1;
    localparam logic [1:0] OP_RUN      = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_GAP_SYMBOL    = 2'd0;
    localparam logic [1:0] CFG_FILTER_ENABLE = 2'd1;
    localparam logic [1:0] CFG_LOG_THRESHOLD = 2'd2;

    localparam int CFG_DATA_W = 32;

    // one stored alignment column
    typedef struct packed {
        logic [7:0]         outer;
        logic [7:0]         anchor;
        logic signed [31:0] post;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

FILE: hw/rtl/aam_ram.sv
// ----------------------------------------------------------------------------
// aam_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module aam_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/anchored_alignment_merge.sv
// ----------------------------------------------------------------------------
// anchored_alignment_merge
// Merges two pairwise alignment columns sharing an anchor row into
// three-row columns, walking two column RAMs with a pair of read pointers.
// ----------------------------------------------------------------------------
// channel | direction | handshake                 | payload
// in      | input     | i_in_valid / o_in_ready   | operation, symbols, posterior
// out     | output    | o_out_valid / i_out_ready | three row symbols, valid_res, last
// cfg     | input     | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// A run starts from idle and walks the columns (one RAM read per store per cycle,
// pointer update from the read data), then ends with an end check and the last
// transfer; walk steps and the last transfer wait while the output register
// stays occupied.
// The kept column is held one step so the final one can carry last.
// Input is taken only between runs. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module anchored_alignment_merge #(
    parameter int MAX_COLUMNS = aam_pkg::MAX_COLUMNS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_operation,
    input  logic [7:0]                    i_outer_symbol,
    input  logic [7:0]                    i_anchor_symbol,
    input  logic signed [31:0]            i_log_posterior,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_row_one_symbol,
    output logic [7:0]                    o_row_two_symbol,
    output logic [7:0]                    o_row_three_symbol,
    output logic                          o_valid_res,
    output logic                          o_last,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [aam_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int LW = $clog2(MAX_COLUMNS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // configuration
    logic [7:0]         r_gap_symbol;
    logic               r_filter_enable;
    logic signed [31:0] r_log_threshold;

    // control
    logic [1:0]    r_state, n_state;
    logic [LW-1:0] r_len1, n_len1, r_len2, n_len2;
    logic [LW-1:0] r_p1, n_p1, r_p2, n_p2;
    logic          r_pend_valid, n_pend_valid;
    logic          r_out_valid, n_out_valid;

    // payload
    logic [7:0] r_pend_row1, n_pend_row1, r_pend_row2, n_pend_row2;
    logic [7:0] r_pend_row3, n_pend_row3;
    logic [7:0] r_out_row1, n_out_row1, r_out_row2, n_out_row2;
    logic [7:0] r_out_row3, n_out_row3;
    logic       r_out_vres, n_out_vres, r_out_last, n_out_last;

    logic                        w_we1, w_we2;
    logic [aam_pkg::ENTRY_W-1:0] w_wdata, w_rd1, w_rd2;
    aam_pkg::t_entry             w_e1, w_e2;
    logic                        w_in_xfer, w_out_free, w_walk_done;
    logic                        w_pass1, w_pass2, w_keep, w_adv1, w_adv2;
    logic [7:0]                  w_row1, w_row2, w_row3;

    assign w_wdata = {i_outer_symbol, i_anchor_symbol, i_log_posterior};

    aam_ram #(
        .WIDTH (aam_pkg::ENTRY_W),
        .DEPTH (MAX_COLUMNS)
    ) u_store_one (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (r_len1[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (n_p1[AW-1:0]),
        .o_rdata (w_rd1)
    );

    aam_ram #(
        .WIDTH (aam_pkg::ENTRY_W),
        .DEPTH (MAX_COLUMNS)
    ) u_store_two (
        .i_clk   (i_clk),
        .i_we    (w_we2),
        .i_waddr (r_len2[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (n_p2[AW-1:0]),
        .o_rdata (w_rd2)
    );

    // read address follows the next pointer, so data for r_p* is here now
    assign w_e1 = aam_pkg::t_entry'(w_rd1);
    assign w_e2 = aam_pkg::t_entry'(w_rd2);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_walk_done = (r_p1 >= r_len1) || (r_p2 >= r_len2);

    assign w_pass1 = !r_filter_enable || ($signed(w_e1.post) > r_log_threshold);
    assign w_pass2 = !r_filter_enable || ($signed(w_e2.post) > r_log_threshold);

    // column selection for one walk step
    always_comb begin
        if (w_e1.anchor == w_e2.anchor) begin
            w_keep = w_pass1 && w_pass2;
            w_row1 = w_e1.outer;
            w_row2 = w_e1.anchor;
            w_row3 = w_e2.outer;
            w_adv1 = 1'b1;
            w_adv2 = 1'b1;
        end else if (w_e1.anchor == r_gap_symbol) begin
            w_keep = w_pass1;
            w_row1 = w_e1.outer;
            w_row2 = w_e1.anchor;
            w_row3 = w_e1.anchor;
            w_adv1 = 1'b1;
            w_adv2 = 1'b0;
        end else begin
            w_keep = w_pass2;
            w_row1 = w_e2.anchor;
            w_row2 = w_e2.anchor;
            w_row3 = w_e2.outer;
            w_adv1 = 1'b0;
            w_adv2 = 1'b1;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_len1       = r_len1;
        n_len2       = r_len2;
        n_p1         = r_p1;
        n_p2         = r_p2;
        n_pend_valid = r_pend_valid;
        n_pend_row1  = r_pend_row1;
        n_pend_row2  = r_pend_row2;
        n_pend_row3  = r_pend_row3;
        n_out_valid  = r_out_valid;
        n_out_row1   = r_out_row1;
        n_out_row2   = r_out_row2;
        n_out_row3   = r_out_row3;
        n_out_vres   = r_out_vres;
        n_out_last   = r_out_last;
        w_we1        = 1'b0;
        w_we2        = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    case (i_operation)
                        aam_pkg::OP_LOAD_ONE: begin
                            if (r_len1 < LW'(MAX_COLUMNS)) begin
                                w_we1  = 1'b1;
                                n_len1 = r_len1 + LW'(1);
                            end
                        end
                        aam_pkg::OP_LOAD_TWO: begin
                            if (r_len2 < LW'(MAX_COLUMNS)) begin
                                w_we2  = 1'b1;
                                n_len2 = r_len2 + LW'(1);
                            end
                        end
                        aam_pkg::OP_RUN: begin
                            n_state      = ST_WALK;
                            n_pend_valid = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                if (w_walk_done) begin
                    n_state = ST_FLUSH;
                end else if (w_out_free) begin
                    n_p1 = r_p1 + LW'(w_adv1);
                    n_p2 = r_p2 + LW'(w_adv2);
                    if (w_keep) begin
                        // previous kept column is not the last one: send it
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_row1  = r_pend_row1;
                            n_out_row2  = r_pend_row2;
                            n_out_row3  = r_pend_row3;
                            n_out_vres  = 1'b1;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_row1  = w_row1;
                        n_pend_row2  = w_row2;
                        n_pend_row3  = w_row3;
                    end
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    if (r_pend_valid) begin
                        n_out_row1 = r_pend_row1;
                        n_out_row2 = r_pend_row2;
                        n_out_row3 = r_pend_row3;
                        n_out_vres = 1'b1;
                    end else begin
                        n_out_row1 = '0;
                        n_out_row2 = '0;
                        n_out_row3 = '0;
                        n_out_vres = 1'b0;
                    end
                    n_pend_valid = 1'b0;
                    n_len1       = '0;
                    n_len2       = '0;
                    n_p1         = '0;
                    n_p2         = '0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_len1          <= '0;
            r_len2          <= '0;
            r_p1            <= '0;
            r_p2            <= '0;
            r_pend_valid    <= 1'b0;
            r_out_valid     <= 1'b0;
            r_gap_symbol    <= '0;
            r_filter_enable <= 1'b0;
            r_log_threshold <= '0;
        end else begin
            r_state      <= n_state;
            r_len1       <= n_len1;
            r_len2       <= n_len2;
            r_p1         <= n_p1;
            r_p2         <= n_p2;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    aam_pkg::CFG_GAP_SYMBOL:    r_gap_symbol    <= i_cfg_data[7:0];
                    aam_pkg::CFG_FILTER_ENABLE: r_filter_enable <= i_cfg_data[0];
                    aam_pkg::CFG_LOG_THRESHOLD: r_log_threshold <= $signed(i_cfg_data[31:0]);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_row1 <= n_pend_row1;
        r_pend_row2 <= n_pend_row2;
        r_pend_row3 <= n_pend_row3;
        r_out_row1  <= n_out_row1;
        r_out_row2  <= n_out_row2;
        r_out_row3  <= n_out_row3;
        r_out_vres  <= n_out_vres;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid        = r_out_valid;
    assign o_row_one_symbol   = r_out_row1;
    assign o_row_two_symbol   = r_out_row2;
    assign o_row_three_symbol = r_out_row3;
    assign o_valid_res        = r_out_vres;
    assign o_last             = r_out_last;

    `AAM_ASSERT(a_ptr_within_len, (r_p1 <= r_len1) && (r_p2 <= r_len2),
        "read pointer past store length")
    `AAM_ASSERT(a_idle_clean,
        (r_state == ST_IDLE) |-> (r_p1 == '0 && r_p2 == '0 && !r_pend_valid),
        "pointers or pending column left over between runs")
    `AAM_ASSERT(a_empty_run_last, (o_out_valid && !o_valid_res) |-> o_last,
        "empty result without last")
    `AAM_ASSERT(a_flush_clears,
        (r_state == ST_FLUSH && w_out_free) |=> (r_state == ST_IDLE && r_len1 == '0 && r_len2 == '0),
        "run end did not clear store lengths")
    `AAM_ASSERT(a_len_bounded,
        (r_len1 <= LW'(MAX_COLUMNS)) && (r_len2 <= LW'(MAX_COLUMNS)),
        "store length beyond capacity")

endmodule

FILE: verif/anchored_alignment_merge_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anchored_alignment_merge_test
// Self-checking bench for the anchored alignment merge. Load and run transfers
// come from a queue that the stimulus process fills with directed cases and
// random merge jobs built around a shared anchor row. A scoreboard model of
// both column stores predicts every merged column. Each phase sets the gap
// symbol and the threshold, some phases the filter too, and the amount of
// idling on both channels.
// ----------------------------------------------------------------------------
module anchored_alignment_merge_test;

    localparam int         DEPTH        = aam_pkg::MAX_COLUMNS_DEF;
    localparam int         DRAIN_CYCLES = 8;
    localparam logic [1:0] OP_NONE      = 2'd3;   // unused code, block ignores it

    typedef struct {
        logic [1:0]         op;
        logic [7:0]         outer;
        logic [7:0]         anchor;
        logic signed [31:0] post;
    } t_item;

    typedef struct packed {
        logic [7:0] row_one;
        logic [7:0] row_two;
        logic [7:0] row_three;
        logic       kept;
        logic       is_last;
    } t_merged;

    logic                           i_clk              = 1'b0;
    logic                           i_rst_n            = 1'b0;
    logic                           i_in_valid         = 1'b0;
    logic                           o_in_ready;
    logic [1:0]                     i_operation        = aam_pkg::OP_LOAD_ONE;
    logic [7:0]                     i_outer_symbol     = '0;
    logic [7:0]                     i_anchor_symbol    = '0;
    logic signed [31:0]             i_log_posterior    = '0;
    logic                           o_out_valid;
    logic                           i_out_ready        = 1'b0;
    logic [7:0]                     o_row_one_symbol;
    logic [7:0]                     o_row_two_symbol;
    logic [7:0]                     o_row_three_symbol;
    logic                           o_valid_res;
    logic                           o_last;
    logic                           i_cfg_we           = 1'b0;
    logic [1:0]                     i_cfg_index        = aam_pkg::CFG_GAP_SYMBOL;
    logic [aam_pkg::CFG_DATA_W-1:0] i_cfg_data         = '0;

    anchored_alignment_merge dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_outer_symbol     (i_outer_symbol),
        .i_anchor_symbol    (i_anchor_symbol),
        .i_log_posterior    (i_log_posterior),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_row_one_symbol   (o_row_one_symbol),
        .o_row_two_symbol   (o_row_two_symbol),
        .o_row_three_symbol (o_row_three_symbol),
        .o_valid_res        (o_valid_res),
        .o_last             (o_last),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // scoreboard copy of the block state
    aam_pkg::t_entry    pair_one_cols [DEPTH];
    aam_pkg::t_entry    pair_two_cols [DEPTH];
    int                 pair_one_len;
    int                 pair_two_len;
    logic [7:0]         gap_sym;
    logic               filt_en;
    logic signed [31:0] thr;

    t_item   pending_items [$];
    t_merged expected_cols [$];
    t_item   drive_item;
    t_merged got_col;
    t_merged exp_col;
    int      sender_idle_pct;
    int      recv_stall_pct;
    int      error_count;
    int      phase_items;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic bit col_passes(input logic signed [31:0] post);
        return !filt_en || (post > thr);
    endfunction

    function automatic void merge_stores();
        int              p1;
        int              p2;
        bit              have_held;
        aam_pkg::t_entry e1;
        aam_pkg::t_entry e2;
        t_merged         held;
        t_merged         col;
        p1 = 0;
        p2 = 0;
        have_held = 1'b0;
        while (p1 < pair_one_len && p2 < pair_two_len) begin
            e1 = pair_one_cols[p1];
            e2 = pair_two_cols[p2];
            col.kept = 1'b0;
            if (e1.anchor == e2.anchor) begin
                if (col_passes(e1.post) && col_passes(e2.post))
                    col = '{e1.outer, e1.anchor, e2.outer, 1'b1, 1'b0};
                p1++;
                p2++;
            end else if (e1.anchor == gap_sym) begin
                if (col_passes(e1.post))
                    col = '{e1.outer, e1.anchor, e1.anchor, 1'b1, 1'b0};
                p1++;
            end else begin
                if (col_passes(e2.post))
                    col = '{e2.anchor, e2.anchor, e2.outer, 1'b1, 1'b0};
                p2++;
            end
            // hold each kept column back one step so the final one gets last
            if (col.kept) begin
                if (have_held)
                    expected_cols.insert(expected_cols.size(), held);
                held = col;
                have_held = 1'b1;
            end
        end
        if (have_held) begin
            held.is_last = 1'b1;
            expected_cols.insert(expected_cols.size(), held);
        end else begin
            expected_cols.insert(expected_cols.size(),
                                 '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1});
        end
        pair_one_len = 0;
        pair_two_len = 0;
    endfunction

    function automatic void predict_item(input t_item it);
        case (it.op)
            aam_pkg::OP_LOAD_ONE: begin
                if (pair_one_len < DEPTH) begin
                    pair_one_cols[pair_one_len] = '{it.outer, it.anchor, it.post};
                    pair_one_len++;
                end
            end
            aam_pkg::OP_LOAD_TWO: begin
                if (pair_two_len < DEPTH) begin
                    pair_two_cols[pair_two_len] = '{it.outer, it.anchor, it.post};
                    pair_two_len++;
                end
            end
            aam_pkg::OP_RUN: merge_stores();
            default: ;
        endcase
    endfunction

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    // driver: input channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                drive_item = pending_items.pop_front();
                i_operation     <= drive_item.op;
                i_outer_symbol  <= drive_item.outer;
                i_anchor_symbol <= drive_item.anchor;
                i_log_posterior <= drive_item.post;
                i_in_valid      <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: predicts on input transfers, checks output transfers
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                predict_item('{i_operation, i_outer_symbol, i_anchor_symbol,
                               i_log_posterior});
            if (o_out_valid && i_out_ready) begin
                got_col = '{o_row_one_symbol, o_row_two_symbol, o_row_three_symbol,
                            o_valid_res, o_last};
                if (expected_cols.size() == 0) begin
                    flag_error($sformatf("unexpected result %h/%h/%h valid_res=%b last=%b",
                        got_col.row_one, got_col.row_two, got_col.row_three,
                        got_col.kept, got_col.is_last));
                end else begin
                    exp_col = expected_cols.pop_front();
                    if (got_col.row_one !== exp_col.row_one
                        || got_col.row_two !== exp_col.row_two
                        || got_col.row_three !== exp_col.row_three
                        || got_col.kept !== exp_col.kept
                        || got_col.is_last !== exp_col.is_last)
                        flag_error($sformatf(
                            "mismatch exp %h/%h/%h v=%b l=%b got %h/%h/%h v=%b l=%b",
                            exp_col.row_one, exp_col.row_two, exp_col.row_three,
                            exp_col.kept, exp_col.is_last,
                            got_col.row_one, got_col.row_two, got_col.row_three,
                            got_col.kept, got_col.is_last));
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            aam_pkg::CFG_GAP_SYMBOL:    gap_sym = val[7:0];
            aam_pkg::CFG_FILTER_ENABLE: filt_en = val[0];
            aam_pkg::CFG_LOG_THRESHOLD: thr     = $signed(val);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // block is idle once everything was sent and every result came back
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_cols.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_item(input logic [1:0] op, input logic [7:0] outer,
                             input logic [7:0] anchor, input logic [31:0] post);
        pending_items.insert(pending_items.size(), '{op, outer, anchor, $signed(post)});
    endtask

    // posteriors cluster on the threshold so the strict compare gets exercised
    function automatic logic signed [31:0] pick_post();
        case ($urandom_range(7))
            0:       return thr;
            1:       return thr + 1;
            2:       return thr - 1;
            3:       return 32'sh7FFF_FFFF;
            4:       return 32'sh8000_0000;
            default: return $signed($urandom);
        endcase
    endfunction

    // Two pairwise alignments over one anchor row: store two mostly replays
    // the non-gap anchors of store one, with its own insertions mixed in.
    task automatic queue_merge_job(input int n1, input int n2, input bit with_run);
        logic [7:0] alph [4];
        logic [7:0] anchors_one [$];
        t_item      ones [$];
        t_item      twos [$];
        logic [7:0] anc;
        int         cur;
        for (int k = 0; k < 4; k++)
            alph[k] = (k == 0 && $urandom_range(3) == 0) ? gap_sym : 8'($urandom);
        for (int i = 0; i < n1; i++) begin
            if ($urandom_range(9) < 3)
                anc = gap_sym;
            else if ($urandom_range(9) == 0)
                anc = 8'($urandom);
            else
                anc = alph[$urandom_range(3)];
            if (anc != gap_sym)
                anchors_one.insert(anchors_one.size(), anc);
            ones.insert(ones.size(),
                        '{aam_pkg::OP_LOAD_ONE, 8'($urandom), anc, pick_post()});
        end
        cur = 0;
        for (int j = 0; j < n2; j++) begin
            if (cur < anchors_one.size() && $urandom_range(9) < 6) begin
                anc = anchors_one[cur];
                cur++;
            end else if ($urandom_range(4) == 0) begin
                anc = 8'($urandom);
            end else begin
                anc = alph[$urandom_range(3)];
            end
            twos.insert(twos.size(),
                        '{aam_pkg::OP_LOAD_TWO, 8'($urandom), anc, pick_post()});
        end
        while (ones.size() != 0 || twos.size() != 0) begin
            if ($urandom_range(19) == 0)
                push_item(OP_NONE, 8'($urandom), 8'($urandom), $urandom);
            if (twos.size() == 0 || (ones.size() != 0 && $urandom_range(1) == 1))
                pending_items.insert(pending_items.size(), ones.pop_front());
            else
                pending_items.insert(pending_items.size(), twos.pop_front());
        end
        if (with_run)
            push_item(aam_pkg::OP_RUN, 8'($urandom), 8'($urandom), $urandom);
        phase_items += n1 + n2 + int'(with_run);
    endtask

    initial begin
        pair_one_len    = 0;
        pair_two_len    = 0;
        gap_sym         = 8'h00;
        filt_en         = 1'b0;
        thr             = '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        error_count     = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(aam_pkg::CFG_GAP_SYMBOL, 32'h0000_0000);
        write_reg(aam_pkg::CFG_FILTER_ENABLE, 32'h0);
        write_reg(aam_pkg::CFG_LOG_THRESHOLD, 32'h0);
        @(negedge i_clk);
        // empty stores, then only store two filled
        push_item(aam_pkg::OP_RUN, 8'h00, 8'h00, 32'h0);
        push_item(aam_pkg::OP_LOAD_TWO, 8'hFF, 8'hFF, 32'h7FFF_FFFF);
        push_item(aam_pkg::OP_RUN, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        push_item(OP_NONE, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        // gap column, matches, store-two insertion, and a dropped trailing column
        push_item(aam_pkg::OP_LOAD_ONE, 8'hFF, 8'h00, 32'h8000_0000);
        push_item(aam_pkg::OP_LOAD_ONE, 8'h00, 8'h5A, 32'h7FFF_FFFF);
        push_item(aam_pkg::OP_LOAD_ONE, 8'h11, 8'h3C, 32'h0);
        push_item(aam_pkg::OP_LOAD_TWO, 8'h22, 8'h5A, 32'hFFFF_FFFF);
        push_item(OP_NONE, 8'h00, 8'h00, 32'h0);
        push_item(aam_pkg::OP_LOAD_TWO, 8'h33, 8'h77, 32'h1);
        push_item(aam_pkg::OP_LOAD_TWO, 8'h44, 8'h3C, 32'h7FFF_FFFF);
        push_item(aam_pkg::OP_LOAD_TWO, 8'h55, 8'h99, 32'h0);
        push_item(aam_pkg::OP_RUN, 8'h00, 8'h00, 32'h0);
        wait_idle();

        // filter: a posterior equal to the threshold is dropped
        write_reg(aam_pkg::CFG_FILTER_ENABLE, 32'h1);
        write_reg(aam_pkg::CFG_LOG_THRESHOLD, 32'h0000_0100);
        @(negedge i_clk);
        push_item(aam_pkg::OP_LOAD_ONE, 8'h10, 8'hA1, 32'h0000_0100);
        push_item(aam_pkg::OP_LOAD_TWO, 8'h20, 8'hA1, 32'h0000_0101);
        push_item(aam_pkg::OP_LOAD_ONE, 8'h11, 8'hA2, 32'h0000_0101);
        push_item(aam_pkg::OP_LOAD_TWO, 8'h21, 8'hA2, 32'h0000_0101);
        push_item(aam_pkg::OP_RUN, 8'h00, 8'h00, 32'h0);
        push_item(aam_pkg::OP_LOAD_ONE, 8'h12, 8'hA3, 32'h0000_0100);
        push_item(aam_pkg::OP_LOAD_TWO, 8'h22, 8'hA3, 32'h0000_0100);
        push_item(aam_pkg::OP_RUN, 8'h00, 8'h00, 32'h0);

        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    write_reg(aam_pkg::CFG_GAP_SYMBOL, $urandom_range(255));
                    write_reg(aam_pkg::CFG_FILTER_ENABLE, 32'h0);
                    write_reg(aam_pkg::CFG_LOG_THRESHOLD, $urandom);
                end
                1: begin
                    write_reg(aam_pkg::CFG_GAP_SYMBOL, 32'h0000_00FF);
                    write_reg(aam_pkg::CFG_FILTER_ENABLE, 32'h1);
                    write_reg(aam_pkg::CFG_LOG_THRESHOLD, 32'h8000_0000);
                end
                2: begin
                    write_reg(aam_pkg::CFG_GAP_SYMBOL, $urandom_range(255));
                    write_reg(aam_pkg::CFG_LOG_THRESHOLD, 32'h0);
                end
                3: begin
                    write_reg(aam_pkg::CFG_GAP_SYMBOL, 32'h0);
                    write_reg(aam_pkg::CFG_LOG_THRESHOLD, 32'h7FFF_FFFF);
                end
                default: begin
                    write_reg(aam_pkg::CFG_GAP_SYMBOL, $urandom_range(255));
                    write_reg(aam_pkg::CFG_LOG_THRESHOLD, $urandom);
                end
            endcase
            @(negedge i_clk);
            sender_idle_pct = (ph == 1) ? 57 : (ph == 3) ? 15 : 0;
            recv_stall_pct  = (ph == 2) ? 57 : (ph == 3) ? 15 : 0;
            phase_items = 0;
            // store one is overfilled in this phase
            if (ph == 1)
                queue_merge_job(DEPTH + 2, $urandom_range(1, 6), 1'b1);
            while (phase_items < 12) begin
                if ($urandom_range(9) == 0)
                    queue_merge_job($urandom_range(28, 34), $urandom_range(0, 6), 1'b1);
                else
                    queue_merge_job($urandom_range(0, 6), $urandom_range(0, 6),
                                    $urandom_range(9) != 0);
            end
            push_item(aam_pkg::OP_RUN, 8'($urandom), 8'($urandom), $urandom);
        end
        wait_idle();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/aam_pkg.sv
hw/rtl/aam_ram.sv
hw/rtl/anchored_alignment_merge.sv
verif/anchored_alignment_merge_test.sv
